// ----- hw/rtl/sbd_pkg.sv -----
package sbd_pkg;

  localparam logic [7:0] HEADER     = 8'h0F;
  localparam int         DATA_BYTES = 22;
  localparam int         DATA_W     = DATA_BYTES * 8;
  localparam int         RAW_W      = 11;
  localparam int         PW_W       = 12;
  localparam int         PROD_W     = 23;
  localparam int         CFG_IDX_W  = 3;
  localparam int         CFG_DATA_W = 12;

  // byte_count value of the flag byte (last stored byte of a frame)
  localparam logic [4:0] FLAG_IDX  = 5'd22;
  localparam logic [4:0] DIV_STEPS = 5'd23;
  localparam logic [3:0] LAST_CH   = 4'd15;

  typedef struct packed {
    logic [3:0]        flags;
    logic [DATA_W-1:0] data;
  } frame_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;

  typedef struct packed {
    logic [RAW_W-1:0] raw_offset;
    logic [RAW_W-1:0] raw_span;
    logic [PW_W-1:0]  out_min;
    logic [PW_W-1:0]  out_span;
  } cfg_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RAW_OFFSET = 3'd0,
    CFG_RAW_SPAN   = 3'd1,
    CFG_OUT_MIN    = 3'd2,
    CFG_OUT_SPAN   = 3'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_MUL,
    B_DIV,
    B_FIN
  } back_state_t;

endpackage

// ----- hw/rtl/sbd_if.sv -----
interface sbd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface sbd_result_if;
  logic        valid;
  logic        ready;
  logic [3:0]  channel_index;
  logic [10:0] raw_value;
  logic [11:0] pulse_width;
  logic        failsafe;
  logic        frame_lost;
  logic        digital_ch17;
  logic        digital_ch18;
  logic        last_channel;
  modport source (output valid, output channel_index, output raw_value, output pulse_width,
                  output failsafe, output frame_lost, output digital_ch17,
                  output digital_ch18, output last_channel, input ready);
  modport sink (input valid, input channel_index, input raw_value, input pulse_width,
                input failsafe, input frame_lost, input digital_ch17,
                input digital_ch18, input last_channel, output ready);
endinterface

interface sbd_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [11:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ----- hw/rtl/sbd_front.sv -----
module sbd_front import sbd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  sbd_byte_if.sink   rx,
  input  q_status_t  q_stat,
  output logic       push,
  output frame_t     push_frame
);

  logic              in_frame;
  logic [4:0]        byte_count;
  logic [DATA_W-1:0] data;
  logic              take;

  assign rx.ready   = !q_stat.full;
  assign take       = rx.valid && rx.ready;
  assign push       = take && in_frame && (byte_count == FLAG_IDX);
  assign push_frame = '{flags: rx.rx_byte[3:0], data: data};

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame   <= 1'b0;
      byte_count <= 5'd0;
    end else if (take) begin
      if (!in_frame) begin
        if (rx.rx_byte == HEADER) begin
          in_frame   <= 1'b1;
          byte_count <= 5'd0;
        end
      end else if (byte_count == FLAG_IDX) begin
        in_frame   <= 1'b0;
        byte_count <= 5'd0;
      end else begin
        byte_count <= byte_count + 5'd1;
      end
    end
  end

  // data bytes shift in from the top; byte 1 ends in the low bits
  always_ff @(posedge clk) begin
    if (take && in_frame && (byte_count != FLAG_IDX)) begin
      data <= {rx.rx_byte, data[DATA_W-1:8]};
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    byte_count <= FLAG_IDX)
    else $error("byte_count beyond flag byte");

endmodule

// ----- hw/rtl/sbd_queue.sv -----
module sbd_queue import sbd_pkg::*; #(
  parameter int DEPTH = 2
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  frame_t    push_frame,
  input  logic      pop,
  output frame_t    head,
  output q_status_t q_stat
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  frame_t        entries [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign head         = entries[rd_ptr];
  assign q_stat.empty = (count == CW'(0));
  assign q_stat.full  = (count == CW'(DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_frame;
    end
  end

  a_count_max: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("frame queue count overflow");

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    push |-> !q_stat.full)
    else $error("push into full frame queue");

endmodule

// ----- hw/rtl/sbd_back.sv -----
module sbd_back import sbd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  q_status_t   q_stat,
  input  frame_t      head,
  output logic        pop,
  sbd_result_if.source res
);

  back_state_t       state;
  back_state_t       state_next;
  logic [DATA_W-1:0] shreg;
  logic [3:0]        flags;
  logic [3:0]        ch;
  logic              neg;
  logic [RAW_W-1:0]  rem;
  logic [PROD_W-1:0] quo;
  logic [4:0]        step;
  logic              load_out;
  logic              out_valid;

  logic [RAW_W-1:0]  raw;
  logic [RAW_W:0]    diff;
  logic [RAW_W-1:0]  mag;
  logic [PROD_W-1:0] prod;
  logic [RAW_W-1:0]  divisor;
  logic [RAW_W:0]    trial;
  logic [RAW_W:0]    sub;
  logic              ge;
  logic [RAW_W-1:0]  rem_n;
  logic [PROD_W+1:0] qx;
  logic [PROD_W+1:0] sq;
  logic [PROD_W+1:0] pw;
  logic [PW_W-1:0]   pw_clamped;

  assign raw     = shreg[RAW_W-1:0];
  assign diff    = {1'b0, raw} - {1'b0, cfg.raw_offset};
  assign mag     = diff[RAW_W] ? RAW_W'(-diff) : diff[RAW_W-1:0];
  assign prod    = {12'd0, mag} * {11'd0, cfg.out_span};
  assign divisor = (cfg.raw_span == '0) ? RAW_W'(1) : cfg.raw_span;

  // restoring divide, one quotient bit per cycle
  assign trial = {rem, quo[PROD_W-1]};
  assign sub   = trial - {1'b0, divisor};
  assign ge    = trial >= {1'b0, divisor};
  assign rem_n = ge ? sub[RAW_W-1:0] : trial[RAW_W-1:0];

  assign qx = {2'b00, quo};
  assign sq = neg ? -qx : qx;
  assign pw = sq + {13'd0, cfg.out_min};

  always_comb begin
    priority if (pw[PROD_W+1]) begin
      pw_clamped = '0;
    end else if (pw[PROD_W:PW_W] != '0) begin
      pw_clamped = '1;
    end else begin
      pw_clamped = pw[PW_W-1:0];
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      B_IDLE: if (!q_stat.empty) state_next = B_MUL;
      B_MUL:  state_next = B_DIV;
      B_DIV:  if (step == DIV_STEPS - 5'd1) state_next = B_FIN;
      B_FIN: begin
        if (load_out) state_next = (ch == LAST_CH) ? B_IDLE : B_MUL;
      end
      default: state_next = B_IDLE;
    endcase
  end

  always_comb begin
    pop      = (state == B_IDLE) && !q_stat.empty;
    load_out = (state == B_FIN) && (!out_valid || res.ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      shreg <= head.data;
      flags <= head.flags;
      ch    <= 4'd0;
    end
    if (state == B_MUL) begin
      neg  <= diff[RAW_W];
      quo  <= prod;
      rem  <= '0;
      step <= 5'd0;
    end
    if (state == B_DIV) begin
      rem  <= rem_n;
      quo  <= {quo[PROD_W-2:0], ge};
      step <= step + 5'd1;
    end
    if (load_out) begin
      res.channel_index <= ch;
      res.raw_value     <= raw;
      res.pulse_width   <= pw_clamped;
      res.failsafe      <= flags[3];
      res.frame_lost    <= flags[2];
      res.digital_ch17  <= flags[0];
      res.digital_ch18  <= flags[1];
      res.last_channel  <= (ch == LAST_CH);
      shreg             <= {RAW_W'(0), shreg[DATA_W-1:RAW_W]};
      ch                <= ch + 4'd1;
    end
  end

  assign res.valid = out_valid;

  a_last_tag: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> (res.last_channel == (res.channel_index == LAST_CH)))
    else $error("last_channel does not match channel 15");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !q_stat.empty)
    else $error("pop from empty frame queue");

  a_div_steps: assert property (@(posedge clk) disable iff (rst)
    (state == B_DIV) |-> (step < DIV_STEPS))
    else $error("divider ran past its step count");

endmodule

// ----- hw/rtl/sbus_frame_decoder.sv -----
// SBUS frame decoder. Bytes on rx are taken one per cycle while the frame queue has
// room; non-header bytes are dropped while hunting for 0x0F, then 23 bytes are stored
// (22 channel bytes and the flag byte, no footer check). Each completed frame enters a
// QUEUE_DEPTH-entry queue, and the back end turns it into 16 beats on result, one per
// channel, in channel order. Each channel goes through the back end in turn: a multiply
// step, the bit-serial divider, then a load of the output register, which waits while
// result is stalled. Pulse width is trunc((raw - raw_offset) * out_span / raw_span) +
// out_min, clamped to 0..4095, with raw_span of zero taken as one. Config writes are
// accepted every cycle; write them only while no frame is in flight.
module sbus_frame_decoder import sbd_pkg::*; #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst,
  sbd_byte_if.sink    rx,
  sbd_result_if.source result,
  sbd_cfg_if.sink     cfg
);

  cfg_t      cfg_regs;
  q_status_t q_stat;
  logic      push;
  frame_t    push_frame;
  logic      pop;
  frame_t    head;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.raw_offset <= 11'd352;
      cfg_regs.raw_span   <= 11'd1344;
      cfg_regs.out_min    <= 12'd1000;
      cfg_regs.out_span   <= 12'd1000;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        CFG_RAW_OFFSET: cfg_regs.raw_offset <= cfg.data[RAW_W-1:0];
        CFG_RAW_SPAN:   cfg_regs.raw_span   <= cfg.data[RAW_W-1:0];
        CFG_OUT_MIN:    cfg_regs.out_min    <= cfg.data;
        CFG_OUT_SPAN:   cfg_regs.out_span   <= cfg.data;
        default: ;
      endcase
    end
  end

  sbd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .rx         (rx),
    .q_stat     (q_stat),
    .push       (push),
    .push_frame (push_frame)
  );

  sbd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_frame (push_frame),
    .pop        (pop),
    .head       (head),
    .q_stat     (q_stat)
  );

  sbd_back u_back (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg_regs),
    .q_stat (q_stat),
    .head   (head),
    .pop    (pop),
    .res    (result)
  );

endmodule
